### src/vkd_pkg.sv
// Shared constants and types for the vertex key dedup table.
`default_nettype none

package vkd_pkg;

    localparam int HASH_W         = 32;
    localparam int DIGIT_W        = 4;
    localparam int ENTRY_NUMBER_W = 9;

    localparam logic [HASH_W-1:0] PRIME_POS = 32'd73856093;
    localparam logic [HASH_W-1:0] PRIME_NRM = 32'd19349663;
    localparam logic [HASH_W-1:0] PRIME_TEX = 32'd83492791;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_HASH,
        ST_SLOT,
        ST_CMP,
        ST_EMIT
    } vkd_state_t;

endpackage

`default_nettype wire

### src/vkd_req_if.sv
// Request channel: mode and vertex key, valid/ready handshake.
`default_nettype none

interface vkd_req_if #(
    parameter int INDEX_BITS = 20
) ();
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic        [INDEX_BITS-1:0] pos_index;
    logic        [INDEX_BITS-1:0] normal_index;
    logic signed [INDEX_BITS:0]   tex_index;

    modport source (
        output valid, mode, pos_index, normal_index, tex_index,
        input  ready
    );

    modport sink (
        input  valid, mode, pos_index, normal_index, tex_index,
        output ready
    );
endinterface

`default_nettype wire

### src/vkd_rsp_if.sv
// Response channel: entry number and status flags, valid/ready handshake.
`default_nettype none

interface vkd_rsp_if ();
    logic       valid;
    logic       ready;
    logic [8:0] entry_number;
    logic       was_new;
    logic       table_full;

    modport source (
        output valid, entry_number, was_new, table_full,
        input  ready
    );

    modport sink (
        input  valid, entry_number, was_new, table_full,
        output ready
    );
endinterface

`default_nettype wire

### src/vkd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module vkd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/vkd_hash.sv
// Key hash: three prime products XORed, reduced to a bucket index.
`default_nettype none

module vkd_hash #(
    parameter int BUCKET_COUNT = 1024,
    parameter int INDEX_BITS   = 20
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic        [INDEX_BITS-1:0]    pos_index,
    input  wire logic        [INDEX_BITS-1:0]    normal_index,
    input  wire logic signed [INDEX_BITS:0]      tex_index,
    output logic                                 done,
    output logic             [$clog2(BUCKET_COUNT)-1:0] bucket
);

    import vkd_pkg::*;

    localparam int  HW      = $clog2(BUCKET_COUNT);
    localparam bit  IS_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;

    logic [HASH_W-1:0] prod_pos_reg;
    logic [HASH_W-1:0] prod_nrm_reg;
    logic [HASH_W-1:0] prod_tex_reg;
    logic              mul_v_reg;
    logic [HASH_W-1:0] hash;

    // sign-extend the texture index, so an absent index hashes as all ones
    always_ff @(posedge clk)
    begin
        prod_pos_reg <= HASH_W'(pos_index) * PRIME_POS;
        prod_nrm_reg <= HASH_W'(normal_index) * PRIME_NRM;
        prod_tex_reg <= HASH_W'(tex_index) * PRIME_TEX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg <= 1'b0;
        end
        else
        begin
            mul_v_reg <= start;
        end
    end

    assign hash = prod_pos_reg ^ prod_nrm_reg ^ prod_tex_reg;

    generate
        if (IS_POW2)
        begin : g_mask
            assign done   = mul_v_reg;
            assign bucket = hash[HW-1:0];
        end
        else
        begin : g_mod
            localparam int VW    = HW + DIGIT_W;
            localparam int STEPS = HASH_W / DIGIT_W;
            localparam int CW    = $clog2(STEPS);

            logic [HASH_W-1:0] digits_reg;
            logic [HW-1:0]     rem_reg;
            logic [HW-1:0]     rem_next;
            logic [CW-1:0]     step_reg;
            logic              busy_reg;
            logic              done_reg;
            logic [VW-1:0]     partial;

            // one digit per cycle: rem = (rem * 16 + digit) mod BUCKET_COUNT
            always_comb
            begin
                partial  = {rem_reg, digits_reg[HASH_W-1 -: DIGIT_W]};
                rem_next = partial[HW-1:0];
                for (int k = 1; k < (1 << DIGIT_W); k++)
                begin
                    if (partial >= VW'(k * BUCKET_COUNT))
                    begin
                        rem_next = HW'(partial - VW'(k * BUCKET_COUNT));
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    step_reg <= '0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    if (mul_v_reg)
                    begin
                        busy_reg <= 1'b1;
                        step_reg <= '0;
                    end
                    else if (busy_reg)
                    begin
                        step_reg <= step_reg + CW'(1);
                        if (step_reg == CW'(STEPS - 1))
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (mul_v_reg)
                begin
                    digits_reg <= hash;
                    rem_reg    <= '0;
                end
                else if (busy_reg)
                begin
                    digits_reg <= digits_reg << DIGIT_W;
                    rem_reg    <= rem_next;
                end
            end

            assign done   = done_reg;
            assign bucket = rem_reg;
        end
    endgenerate

endmodule

`default_nettype wire

### src/vertex_key_dedup_hash.sv
// Vertex key find-or-insert table with linear probing over a bucket RAM and a key RAM.
// Steps: the key is hashed (and, for a bucket count that is not a power of two, reduced
// modulo the count, 4 bits per cycle), the bucket RAM is read, and each full bucket's key
// is read and compared before the next bucket is probed; an empty bucket takes a new key.
// A new request is taken only when idle, after the last result has gone to the output register.
// Reset and clear: a sweep writes zero to every bucket of the bucket RAM; no request
// is taken until it ends. Clear answers first, then sweeps.
`default_nettype none

module vertex_key_dedup_hash #(
    parameter int BUCKET_COUNT = 1024,
    parameter int INDEX_BITS   = 20
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    vkd_req_if.sink     req,
    vkd_rsp_if.source   rsp
);

    import vkd_pkg::*;

    localparam int ENTRY_LIMIT = BUCKET_COUNT / 2;
    localparam int HW          = $clog2(BUCKET_COUNT);
    localparam int EW          = $clog2(ENTRY_LIMIT);
    localparam int BW          = $clog2(ENTRY_LIMIT + 1);
    localparam int KW          = 3 * INDEX_BITS + 1;
    localparam int ENW         = ENTRY_NUMBER_W;

    vkd_state_t state_reg, state_next;
    logic [HW-1:0]  sweep_reg, sweep_next;
    logic [BW-1:0]  count_reg, count_next;
    logic [HW-1:0]  h_reg, h_next;
    logic [EW-1:0]  e_reg, e_next;
    logic [KW-1:0]  key_reg, key_next;
    logic           out_valid_reg, out_valid_next;
    logic [ENW-1:0] out_entry_reg, out_entry_next;
    logic           out_new_reg, out_new_next;
    logic           out_full_reg, out_full_next;
    logic [ENW-1:0] res_entry_reg, res_entry_next;
    logic           res_new_reg, res_new_next;
    logic           res_full_reg, res_full_next;
    logic           res_clear_reg, res_clear_next;

    logic           bkt_we;
    logic [HW-1:0]  bkt_waddr;
    logic [BW-1:0]  bkt_wdata;
    logic [HW-1:0]  bkt_raddr;
    logic [BW-1:0]  bkt_rdata;
    logic           key_we;
    logic [EW-1:0]  key_waddr;
    logic [KW-1:0]  key_wdata;
    logic [EW-1:0]  key_raddr;
    logic [KW-1:0]  key_rdata;

    logic           hash_done;
    logic [HW-1:0]  hash_bucket;

    logic           accept;
    logic           out_free;
    logic           slot_step;
    logic [HW-1:0]  h_inc;
    logic [EW-1:0]  slot_entry;
    logic           fin;
    logic [ENW-1:0] fin_entry;
    logic           fin_new;
    logic           fin_full;
    logic           fin_clear;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid        = out_valid_reg;
    assign rsp.entry_number = out_entry_reg;
    assign rsp.was_new      = out_new_reg;
    assign rsp.table_full   = out_full_reg;

    vkd_hash #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .INDEX_BITS   (INDEX_BITS)
    ) u_hash (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept && !req.mode),
        .pos_index    (req.pos_index),
        .normal_index (req.normal_index),
        .tex_index    (req.tex_index),
        .done         (hash_done),
        .bucket       (hash_bucket)
    );

    // bucket holds entry number plus one, zero when empty
    vkd_ram #(
        .WIDTH (BW),
        .DEPTH (BUCKET_COUNT)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .raddr (bkt_raddr),
        .rdata (bkt_rdata)
    );

    vkd_ram #(
        .WIDTH (KW),
        .DEPTH (ENTRY_LIMIT)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    assign h_inc      = (h_reg == HW'(BUCKET_COUNT - 1)) ? '0 : h_reg + HW'(1);
    assign slot_entry = EW'(bkt_rdata - BW'(1));

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        count_next     = count_reg;
        h_next         = h_reg;
        e_next         = e_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_entry_next = out_entry_reg;
        out_new_next   = out_new_reg;
        out_full_next  = out_full_reg;
        res_entry_next = res_entry_reg;
        res_new_next   = res_new_reg;
        res_full_next  = res_full_reg;
        res_clear_next = res_clear_reg;

        bkt_we    = 1'b0;
        bkt_waddr = h_reg;
        bkt_wdata = '0;
        bkt_raddr = h_reg;
        key_we    = 1'b0;
        key_waddr = count_reg[EW-1:0];
        key_wdata = key_reg;
        key_raddr = e_reg;

        slot_step = 1'b0;
        fin       = 1'b0;
        fin_entry = '0;
        fin_new   = 1'b0;
        fin_full  = 1'b0;
        fin_clear = 1'b0;

        case (state_reg)
            ST_SWEEP:
            begin
                bkt_we    = 1'b1;
                bkt_waddr = sweep_reg;
                if (sweep_reg == HW'(BUCKET_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + HW'(1);
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next = {req.pos_index, req.normal_index, req.tex_index};
                    if (req.mode)
                    begin
                        fin        = 1'b1;
                        fin_clear  = 1'b1;
                        count_next = '0;
                    end
                    else
                    begin
                        state_next = ST_HASH;
                    end
                end
            end

            ST_HASH:
            begin
                if (hash_done)
                begin
                    bkt_raddr  = hash_bucket;
                    h_next     = hash_bucket;
                    state_next = ST_SLOT;
                end
            end

            ST_SLOT:
            begin
                slot_step = 1'b1;
            end

            ST_CMP:
            begin
                if (key_rdata == key_reg)
                begin
                    fin       = 1'b1;
                    fin_entry = ENW'(e_reg);
                end
                else
                begin
                    slot_step = 1'b1;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_entry_next = res_entry_reg;
                    out_new_next   = res_new_reg;
                    out_full_next  = res_full_reg;
                    sweep_next     = '0;
                    state_next     = res_clear_reg ? ST_SWEEP : ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // bucket data is on the read port: stop at empty, else fetch its key and the next bucket
        if (slot_step)
        begin
            if (bkt_rdata == '0)
            begin
                fin = 1'b1;
                if (count_reg == BW'(ENTRY_LIMIT))
                begin
                    fin_full = 1'b1;
                end
                else
                begin
                    bkt_we     = 1'b1;
                    bkt_waddr  = h_reg;
                    bkt_wdata  = count_reg + BW'(1);
                    key_we     = 1'b1;
                    key_waddr  = count_reg[EW-1:0];
                    fin_entry  = ENW'(count_reg);
                    fin_new    = 1'b1;
                    count_next = count_reg + BW'(1);
                end
            end
            else
            begin
                key_raddr  = slot_entry;
                e_next     = slot_entry;
                bkt_raddr  = h_inc;
                h_next     = h_inc;
                state_next = ST_CMP;
            end
        end

        // load the output register directly when free, else hold the result
        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_entry_next = fin_entry;
                out_new_next   = fin_new;
                out_full_next  = fin_full;
                sweep_next     = '0;
                state_next     = fin_clear ? ST_SWEEP : ST_IDLE;
            end
            else
            begin
                res_entry_next = fin_entry;
                res_new_next   = fin_new;
                res_full_next  = fin_full;
                res_clear_next = fin_clear;
                state_next     = ST_EMIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            res_clear_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            res_clear_reg <= res_clear_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg         <= h_next;
        e_reg         <= e_next;
        key_reg       <= key_next;
        out_entry_reg <= out_entry_next;
        out_new_reg   <= out_new_next;
        out_full_reg  <= out_full_next;
        res_entry_reg <= res_entry_next;
        res_new_reg   <= res_new_next;
        res_full_reg  <= res_full_next;
    end

endmodule

`default_nettype wire
